// File: rtl/core/swmm_pkg.sv
// Package for the sliding-window minimum/maximum block.
// Holds the field widths, the default window depth and the token type
// that travels along the cell chain. No dependencies.
package swmm_pkg;

  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned WSIZE_W        = 11;
  localparam int unsigned WINDOW_MAX_DEF = 1024;

  // Partial result passed from cell to cell, oldest sample toward newest.
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
  } swmm_token_t;

endpackage

// File: rtl/core/swmm_ifs.sv
// Valid/ready channel interfaces of the sliding-window min/max block:
// sample input, min/max result and window-size configuration.
// Uses swmm_pkg for the field widths.
interface swmm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swmm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] window_min;
  logic signed [swmm_pkg::SAMPLE_W-1:0] window_max;

  modport source (output valid, output window_min, output window_max, input ready);
  modport sink (input valid, input window_min, input window_max, output ready);
endinterface

interface swmm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [swmm_pkg::WSIZE_W-1:0]        window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

// File: rtl/core/sliding_window_min_max.sv
// Top level of the sliding-window minimum/maximum block: control, the
// chain of swmm_cell instances and the output registers.
// Depends on swmm_pkg, swmm_ifs and swmm_cell.
//
//   port      dir  fields                      meaning
//   in_beat   in   sample                      next sample into the window
//   out_beat  out  window_min, window_max      extremes of the full window
//   cfg_beat  in   window_size                 window length, 0 acts as 1
//
// A sample beat shifts the chain; when the window is full, a token starts at
// the oldest window cell the next cycle and walks one cell per cycle to
// cell 0 and from there into a holding register; the input is stalled from
// that sample until the holding register is empty again, and a sample that
// does not fill the window leaves it ready. Reset leaves an empty window of
// size 1. A result that waits for out_beat.ready is kept in the output
// register while the next sample is already taken; a second result then
// waits in the holding register and stops the input.
module sliding_window_min_max #(
  parameter int unsigned WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swmm_in_if.sink    in_beat,
  swmm_out_if.source out_beat,
  swmm_cfg_if.sink   cfg_beat
);
  import swmm_pkg::*;

  localparam int unsigned IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_MAX + 1);

  logic [WSIZE_W-1:0]         wsize_r;
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          fill_nxt;
  logic [FILL_W-1:0]          eff_size;
  logic [IDX_W-1:0]           launch_idx;
  logic                       busy_r;
  logic                       start_r;
  logic                       pend_v_r;
  logic signed [SAMPLE_W-1:0] pend_lo_r;
  logic signed [SAMPLE_W-1:0] pend_hi_r;
  logic                       out_v_r;
  logic signed [SAMPLE_W-1:0] out_min_r;
  logic signed [SAMPLE_W-1:0] out_max_r;
  logic                       in_acc;
  logic                       full_now;
  logic                       out_load;

  logic signed [SAMPLE_W-1:0] samp [WINDOW_MAX];
  swmm_token_t                tok  [WINDOW_MAX+1];

  // Window size saturated into 1..WINDOW_MAX.
  always_comb begin
    priority if (wsize_r == '0) begin
      eff_size = FILL_W'(1);
    end else if (32'(wsize_r) > WINDOW_MAX) begin
      eff_size = FILL_W'(WINDOW_MAX);
    end else begin
      eff_size = FILL_W'(wsize_r);
    end
  end

  assign launch_idx = IDX_W'(eff_size - FILL_W'(1));

  assign in_beat.ready  = !busy_r && !pend_v_r;
  assign cfg_beat.ready = 1'b1;
  assign in_acc         = in_beat.valid && in_beat.ready;

  assign fill_nxt = (fill_r < eff_size) ? fill_r + FILL_W'(1) : fill_r;
  assign full_now = (fill_nxt == eff_size);
  assign out_load = pend_v_r && (!out_v_r || out_beat.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r  <= WSIZE_W'(1);
      fill_r   <= '0;
      busy_r   <= 1'b0;
      start_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      start_r <= in_acc && full_now;
      if (cfg_beat.valid) begin
        wsize_r <= cfg_beat.window_size;
        fill_r  <= '0;
      end else if (in_acc) begin
        fill_r <= fill_nxt;
      end
      if (in_acc && full_now) begin
        busy_r <= 1'b1;
      end else if (tok[0].vld) begin
        busy_r <= 1'b0;
      end
      if (tok[0].vld) begin
        pend_v_r <= 1'b1;
      end else if (out_load) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[0].vld) begin
      pend_lo_r <= tok[0].lo;
      pend_hi_r <= tok[0].hi;
    end
    if (out_load) begin
      out_min_r <= pend_lo_r;
      out_max_r <= pend_hi_r;
    end
  end

  assign tok[WINDOW_MAX] = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] cell_in;

    if (i == 0) begin : g_head
      assign cell_in = in_beat.sample;
    end else begin : g_body
      assign cell_in = samp[i-1];
    end

    swmm_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (in_acc),
      .sample_in  (cell_in),
      .sample_out (samp[i]),
      .start      (start_r),
      .launch_idx (launch_idx),
      .tok_in     (tok[i+1]),
      .tok_out    (tok[i])
    );
  end

  assign out_beat.valid      = out_v_r;
  assign out_beat.window_min = out_min_r;
  assign out_beat.window_max = out_max_r;

endmodule

// File: rtl/core/swmm_cell.sv
// One cell of the window chain: holds one sample of the shift line and
// merges it into the min/max token that passes through on its way out.
// Depends on swmm_pkg.
module swmm_cell #(
  parameter int unsigned IDX_W    = 10,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                 start,
  input  logic [IDX_W-1:0]                     launch_idx,
  input  swmm_pkg::swmm_token_t                tok_in,
  output swmm_pkg::swmm_token_t                tok_out
);
  import swmm_pkg::*;

  logic signed [SAMPLE_W-1:0] data_r;
  swmm_token_t                tok_r;
  swmm_token_t                tok_nxt;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= sample_in;
    end
  end

  always_comb begin
    tok_nxt = '0;
    priority if (start && (launch_idx == IDX_W'(CELL_IDX))) begin
      // The oldest sample of the window opens the token.
      tok_nxt.vld = 1'b1;
      tok_nxt.lo  = data_r;
      tok_nxt.hi  = data_r;
    end else if (tok_in.vld) begin
      tok_nxt.vld = 1'b1;
      tok_nxt.lo  = (data_r < tok_in.lo) ? data_r : tok_in.lo;
      tok_nxt.hi  = (data_r > tok_in.hi) ? data_r : tok_in.hi;
    end else begin
      tok_nxt = tok_in;
    end
  end

  // Only the valid bit is reset; the extremes are don't-care while it is low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.lo <= tok_nxt.lo;
    tok_r.hi <= tok_nxt.hi;
  end

  assign sample_out = data_r;
  assign tok_out    = tok_r;

endmodule
